FILE: sv/cfl_pkg.sv
// types, codes and constants shared by the fault log modules
package cfl_pkg;

    localparam int unsigned LOG_DEPTH_DEF = 16;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned SEV_W   = 3;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MAXR_W  = 5;
    localparam int unsigned ACT_W   = 16;
    localparam int unsigned FILL_W  = 5;
    localparam int unsigned REC_W   = TIME_W + CODE_W + SEV_W;
    localparam int unsigned IN_W    = CODE_W + SEV_W + TIME_W + MAXR_W;
    localparam int unsigned OUT_W   = TIME_W + CODE_W + SEV_W + ACT_W + FILL_W;
    localparam int unsigned PADDR_W = 2;
    localparam int unsigned PDATA_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_RAISE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SNAP  = 2'd2;

    localparam logic [MAXR_W-1:0] RESULT_CAP   = 5'd16;
    localparam logic [ACT_W-1:0]  ACTIVE_MAX   = 16'hFFFF;
    localparam logic [FILL_W-1:0] FILL_OUT_MAX = 5'd31;
    localparam logic [SEV_W-1:0]  WARN_RESET   = 3'd1;

    localparam logic [PADDR_W-1:0] ADDR_WARN_LEVEL = 2'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SNAP
    } cfl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic snap_start;
        logic emit;
    } cfl_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              snap_empty;
        logic              out_free;
        logic              last_rec;
    } cfl_stat_t;

endpackage

FILE: sv/cfl_ctrl.sv
// controller state machine of the fault log
module cfl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cfl_pkg::cfl_stat_t stat,
    output cfl_pkg::cfl_cmd_t  cmd
);
    import cfl_pkg::*;

    cfl_state_t state_reg;
    cfl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    if (stat.func == FUNC_SNAP && !stat.snap_empty)
                    begin
                        state_next = ST_SNAP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SNAP:
            begin
                if (stat.out_free && stat.last_rec)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    if (stat.func == FUNC_SNAP && !stat.snap_empty)
                    begin
                        cmd.snap_start = 1'b1;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            ST_SNAP:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/cfl_datapath.sv
// record ring, counters, snapshot read pointer and output register
module cfl_datapath
#(
    parameter int unsigned LOG_DEPTH = cfl_pkg::LOG_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cfl_pkg::SEV_W-1:0]   warn_level,
    input  logic [cfl_pkg::IN_W-1:0]    s_tdata,
    input  logic [cfl_pkg::FUNC_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cfl_pkg::OUT_W-1:0]   m_tdata,
    output logic [0:0]                  m_tuser,
    output logic                        m_tlast,
    input  cfl_pkg::cfl_cmd_t           cmd,
    output cfl_pkg::cfl_stat_t          stat
);
    import cfl_pkg::*;

    localparam int unsigned IW = $clog2(LOG_DEPTH);
    localparam int unsigned CW = $clog2(LOG_DEPTH + 1);

    // captured item
    logic [FUNC_W-1:0] func_reg;
    logic [CODE_W-1:0] code_reg;
    logic [SEV_W-1:0]  sev_reg;
    logic [TIME_W-1:0] time_reg;
    logic [MAXR_W-1:0] maxr_reg;

    // log state
    logic [REC_W-1:0]  rec_mem_reg [LOG_DEPTH];
    logic [REC_W-1:0]  rd_data_reg;
    logic [IW-1:0]     head_reg;
    logic [IW-1:0]     head_next;
    logic [CW-1:0]     held_reg;
    logic [CW-1:0]     held_next;
    logic [ACT_W-1:0]  active_reg;
    logic [ACT_W-1:0]  active_next;

    // snapshot walk
    logic [IW-1:0]     ptr_reg;
    logic [IW-1:0]     ptr_next;
    logic [MAXR_W-1:0] remain_reg;
    logic [MAXR_W-1:0] remain_next;
    logic [IW-1:0]     snap_base;
    logic [MAXR_W-1:0] snap_len;
    logic [IW-1:0]     rd_addr;
    logic              rd_en;
    logic              last_rec;

    // output register
    logic              out_valid_reg;
    logic              out_last_reg;
    logic              out_rec_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_free;
    logic [FILL_W-1:0] fill_sat;
    logic              do_raise;
    logic              do_clear;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
        logic [IW-1:0] res;
        if (idx == IW'(LOG_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= s_tuser;
            code_reg <= s_tdata[CODE_W-1:0];
            sev_reg  <= s_tdata[CODE_W +: SEV_W];
            time_reg <= s_tdata[CODE_W+SEV_W +: TIME_W];
            maxr_reg <= s_tdata[CODE_W+SEV_W+TIME_W +: MAXR_W];
        end
    end

    assign do_raise = cmd.exec && func_reg == FUNC_RAISE;
    assign do_clear = cmd.exec && func_reg == FUNC_CLEAR;

    always_comb
    begin
        head_next   = head_reg;
        held_next   = held_reg;
        active_next = active_reg;
        if (do_raise)
        begin
            head_next = wrap_inc(head_reg);
            if (held_reg < CW'(LOG_DEPTH))
            begin
                held_next = held_reg + 1'b1;
            end
            if (sev_reg >= warn_level && active_reg != ACTIVE_MAX)
            begin
                active_next = active_reg + 1'b1;
            end
        end
        else if (do_clear)
        begin
            head_next   = '0;
            held_next   = '0;
            active_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            held_reg   <= '0;
            active_reg <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            held_reg   <= held_next;
            active_reg <= active_next;
        end
    end

    // number of records a snapshot returns and the oldest slot
    always_comb
    begin
        logic [31:0] n;
        n = 32'(held_reg);
        if (32'(maxr_reg) < n)
        begin
            n = 32'(maxr_reg);
        end
        if (32'(RESULT_CAP) < n)
        begin
            n = 32'(RESULT_CAP);
        end
        snap_len = n[MAXR_W-1:0];
        if (held_reg < CW'(LOG_DEPTH))
        begin
            snap_base = '0;
        end
        else
        begin
            snap_base = head_reg;
        end
    end

    assign last_rec = remain_reg == MAXR_W'(1);
    assign rd_en    = cmd.snap_start || (cmd.emit && !last_rec);
    assign rd_addr  = cmd.snap_start ? snap_base : ptr_reg;

    always_comb
    begin
        ptr_next    = ptr_reg;
        remain_next = remain_reg;
        if (cmd.snap_start)
        begin
            ptr_next    = wrap_inc(snap_base);
            remain_next = snap_len;
        end
        else if (cmd.emit)
        begin
            ptr_next    = wrap_inc(ptr_reg);
            remain_next = remain_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            remain_reg <= '0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_raise)
        begin
            rec_mem_reg[head_reg] <= {sev_reg, code_reg, time_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= rec_mem_reg[rd_addr];
        end
    end

    // status fields after this item
    always_comb
    begin
        if (32'(held_next) > 32'(FILL_OUT_MAX))
        begin
            fill_sat = FILL_OUT_MAX;
        end
        else
        begin
            fill_sat = FILL_W'(held_next);
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec || cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_rec_reg  <= 1'b0;
            out_last_reg <= 1'b1;
            out_data_reg <= {fill_sat, active_next, {REC_W{1'b0}}};
        end
        else if (cmd.emit)
        begin
            out_rec_reg  <= 1'b1;
            out_last_reg <= last_rec;
            out_data_reg <= {fill_sat, active_next, rd_data_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_rec_reg;
    assign m_tlast  = out_last_reg;

    assign stat.func       = func_reg;
    assign stat.snap_empty = snap_len == '0;
    assign stat.out_free   = out_free;
    assign stat.last_rec   = last_rec;

endmodule

FILE: sv/circular_fault_log_core.sv
// circular fault log: top level with configuration register
// raise, clear and status words: captured, then the result is registered; one item in flight
// snapshot: first record read from memory, then registered; then one record a cycle while
// the output is not stalled, set by the single read port of the record memory
// a new word is taken as soon as the last result sits in the output register
// reset clears head, fill count, active counter and sets warn_level to 1; records undefined
module circular_fault_log_core
#(
    parameter int unsigned LOG_DEPTH = cfl_pkg::LOG_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // fault_code, severity, time_ms, max_records
    input  logic [cfl_pkg::IN_W-1:0]     s_tdata,
    // func
    input  logic [cfl_pkg::FUNC_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // rec_time, rec_code, rec_severity, active_count, fill_count
    output logic [cfl_pkg::OUT_W-1:0]    m_tdata,
    // rec_valid
    output logic [0:0]                   m_tuser,
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cfl_pkg::PADDR_W-1:0]  paddr,
    input  logic [cfl_pkg::PDATA_W-1:0]  pwdata,
    output logic [cfl_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import cfl_pkg::*;

    logic [SEV_W-1:0] warn_level_reg;
    logic             cfg_wr;
    cfl_cmd_t         cmd;
    cfl_stat_t        stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_level_reg <= WARN_RESET;
        end
        else if (cfg_wr && paddr == ADDR_WARN_LEVEL)
        begin
            warn_level_reg <= pwdata[SEV_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr)
            ADDR_WARN_LEVEL: prdata = PDATA_W'(warn_level_reg);
            default:         prdata = '0;
        endcase
    end

    cfl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cfl_datapath
    #(
        .LOG_DEPTH (LOG_DEPTH)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .warn_level (warn_level_reg),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule
